// File: design/rbfi_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and fixed-point helpers for the rigid body force integrator.
// Used by rbfi_ctrl, rbfi_datapath and the top level; depends on nothing.
package rbfi_pkg;

    localparam int FORCE_SLOTS_DEFAULT = 16;

    // Configuration register indexes.
    localparam logic REG_INVERSE_MASS    = 1'b0;
    localparam logic REG_TORQUE_DISABLED = 1'b1;

    localparam logic [31:0] INVM_RESET = 32'h0001_0000;

    // Squared offset length limit, 0.01 in Q32.32.
    localparam logic signed [66:0] LEN2_LIMIT = 67'sd42949673;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Request types.
    localparam logic [1:0] REQ_IMMEDIATE = 2'd0;
    localparam logic [1:0] REQ_KEYED     = 2'd1;
    localparam logic [1:0] REQ_STEP      = 2'd2;

    // Multiplier operand A sources.
    localparam logic [2:0] A_MAG  = 3'd0;
    localparam logic [2:0] A_FV   = 3'd1;
    localparam logic [2:0] A_OV   = 3'd2;
    localparam logic [2:0] A_TQ   = 3'd3;
    localparam logic [2:0] A_LAT  = 3'd4;
    localparam logic [2:0] A_AAT  = 3'd5;
    localparam logic [2:0] A_VEL  = 3'd6;
    localparam logic [2:0] A_AVEL = 3'd7;

    // Multiplier operand B sources.
    localparam logic [1:0] B_DIR  = 2'd0;
    localparam logic [1:0] B_INVM = 2'd1;
    localparam logic [1:0] B_OV   = 2'd2;
    localparam logic [1:0] B_DT   = 2'd3;

    // Writeback destinations.
    localparam logic [3:0] D_NONE    = 4'd0;
    localparam logic [3:0] D_FV      = 4'd1;
    localparam logic [3:0] D_TQ      = 4'd2;
    localparam logic [3:0] D_VEL     = 4'd3;
    localparam logic [3:0] D_LA      = 4'd4;
    localparam logic [3:0] D_AA      = 4'd5;
    localparam logic [3:0] D_LAT     = 4'd6;
    localparam logic [3:0] D_AAT     = 4'd7;
    localparam logic [3:0] D_POS     = 4'd8;
    localparam logic [3:0] D_AVEL    = 4'd9;
    localparam logic [3:0] D_ROT     = 4'd10;
    localparam logic [3:0] D_ACC_LD  = 4'd11;
    localparam logic [3:0] D_ACC_ADD = 4'd12;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [2:0] a_sel;
        logic [1:0] a_idx;
        logic [1:0] b_sel;
        logic [1:0] b_idx;
        logic [3:0] dest;
        logic [1:0] dest_idx;
        logic       sub_acc;
        logic       prep_off;
        logic       copy_sums;
        logic       zero_aaz;
        logic       slot_write;
        logic       slot_read;
        logic       load_slot;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic       torque_disabled;
        logic       impulse;
        logic [1:0] req;
        logic       slot_valid;
        logic       lin_small;
    } stat_t;

    // Shift right by 16 (floor) and saturate to 32 bits.
    function automatic logic signed [31:0] sat_floor(input logic signed [66:0] v);
        logic signed [50:0] f;
        f = v[66:16];
        if (f > Q_MAX)
            return Q_MAX;
        else if (f < Q_MIN)
            return Q_MIN;
        else
            return f[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > Q_MAX)
            return Q_MAX;
        else if (s < Q_MIN)
            return Q_MIN;
        else
            return s[31:0];
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s > Q_MAX)
            return Q_MAX;
        else if (s < Q_MIN)
            return Q_MIN;
        else
            return s[31:0];
    endfunction

    function automatic logic signed [31:0] pick3(input vec3_t v, input logic [1:0] i);
        case (i)
            2'd0:    return $signed(v[0]);
            2'd1:    return $signed(v[1]);
            default: return $signed(v[2]);
        endcase
    endfunction

    function automatic logic [1:0] next3(input logic [1:0] i);
        case (i)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

endpackage

// File: design/rbfi_datapath.sv
`timescale 1ns / 1ps
// Datapath: item capture, body state, force slot memory and the shared multiplier.
// Depends on rbfi_pkg; driven by rbfi_ctrl through cmd_t, reports through stat_t.
module rbfi_datapath
    import rbfi_pkg::*;
#(
    parameter int FORCE_SLOTS = FORCE_SLOTS_DEFAULT,
    localparam int SLOT_AW = (FORCE_SLOTS > 1) ? $clog2(FORCE_SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [SLOT_AW-1:0]  slot_addr,
    output stat_t               stat,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  magnitude,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  logic signed [31:0]  off_x,
    input  logic signed [31:0]  off_y,
    input  logic signed [31:0]  off_z,
    input  logic                local_offset,
    input  logic                is_impulse,
    input  logic [3:0]          slot,
    input  logic [15:0]         time_delta,
    input  logic [1:0]          req_type,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic signed [31:0]  rot_x,
    output logic signed [31:0]  rot_y,
    output logic signed [31:0]  rot_z
);

    // Configuration.
    logic [31:0] invm_reg;
    logic        td_reg;

    // Captured item.
    logic signed [31:0] mag_reg;
    vec3_t              dir_reg;
    logic               local_reg;
    logic               impulse_reg;
    logic [SLOT_AW-1:0] slot_reg;
    logic               range_reg;
    logic [15:0]        dt_reg;
    logic [1:0]         req_reg;

    // Working vectors.
    vec3_t fv_reg, ov_reg, tq_reg, lat_reg, aat_reg;
    // Persistent body state.
    vec3_t vel_reg, la_reg, aa_reg, avel_reg, pos_reg, rot_reg;
    vec3_t pos_out_reg, rot_out_reg;

    logic signed [66:0] acc_reg;
    logic signed [65:0] prod_reg;
    logic               wb_valid_reg;
    logic [3:0]         wb_dest_reg;
    logic [1:0]         wb_idx_reg;
    logic               wb_sub_reg;

    logic [191:0]           mem [FORCE_SLOTS];
    logic [191:0]           rdata_reg;
    logic [FORCE_SLOTS-1:0] valid_reg;

    logic signed [32:0] a_op, b_op;
    logic signed [66:0] wb_val;
    logic signed [31:0] q_val, old_val, sum_val;
    logic [31:0]        slot_full;

    assign slot_full = 32'(slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invm_reg <= INVM_RESET;
            td_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INVERSE_MASS:    invm_reg <= cfg_data;
                REG_TORQUE_DISABLED: td_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg     <= magnitude;
            dir_reg     <= {dir_z, dir_y, dir_x};
            local_reg   <= local_offset;
            impulse_reg <= is_impulse;
            slot_reg    <= slot_full[SLOT_AW-1:0];
            range_reg   <= slot_full < 32'(FORCE_SLOTS);
            dt_reg      <= time_delta;
            req_reg     <= req_type;
        end
    end

    // Operand selection for the one shared 33x33 multiplier.
    always_comb
    begin
        case (cmd.a_sel)
            A_MAG:   a_op = 33'(mag_reg);
            A_FV:    a_op = 33'(pick3(fv_reg, cmd.a_idx));
            A_OV:    a_op = 33'(pick3(ov_reg, cmd.a_idx));
            A_TQ:    a_op = 33'(pick3(tq_reg, cmd.a_idx));
            A_LAT:   a_op = 33'(pick3(lat_reg, cmd.a_idx));
            A_AAT:   a_op = 33'(pick3(aat_reg, cmd.a_idx));
            A_VEL:   a_op = 33'(pick3(vel_reg, cmd.a_idx));
            default: a_op = 33'(pick3(avel_reg, cmd.a_idx));
        endcase
        case (cmd.b_sel)
            B_DIR:   b_op = 33'(pick3(dir_reg, cmd.b_idx));
            B_INVM:  b_op = $signed({1'b0, invm_reg});
            B_OV:    b_op = 33'(pick3(ov_reg, cmd.b_idx));
            default: b_op = $signed({17'b0, dt_reg});
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else
            wb_valid_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg    <= a_op * b_op;
            wb_dest_reg <= cmd.dest;
            wb_idx_reg  <= cmd.dest_idx;
            wb_sub_reg  <= cmd.sub_acc;
        end
    end

    // Writeback: the second product of a cross term is subtracted from the first.
    always_comb
    begin
        wb_val = wb_sub_reg ? (acc_reg - 67'(prod_reg)) : 67'(prod_reg);
        q_val  = sat_floor(wb_val);
        case (wb_dest_reg)
            D_VEL:   old_val = pick3(vel_reg, wb_idx_reg);
            D_LA:    old_val = pick3(la_reg, wb_idx_reg);
            D_AA:    old_val = pick3(aa_reg, wb_idx_reg);
            D_LAT:   old_val = pick3(lat_reg, wb_idx_reg);
            D_AAT:   old_val = pick3(aat_reg, wb_idx_reg);
            D_POS:   old_val = pick3(pos_reg, wb_idx_reg);
            D_AVEL:  old_val = pick3(avel_reg, wb_idx_reg);
            D_ROT:   old_val = pick3(rot_reg, wb_idx_reg);
            default: old_val = '0;
        endcase
        sum_val = add_sat(old_val, q_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg  <= '0;
            la_reg   <= '0;
            aa_reg   <= '0;
            avel_reg <= '0;
            pos_reg  <= '0;
            rot_reg  <= '0;
        end
        else if (wb_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (wb_idx_reg == 2'(i))
                begin
                    case (wb_dest_reg)
                        D_VEL:   vel_reg[i]  <= sum_val;
                        D_LA:    la_reg[i]   <= sum_val;
                        D_AA:    aa_reg[i]   <= sum_val;
                        D_AVEL:  avel_reg[i] <= sum_val;
                        D_POS:   pos_reg[i]  <= sum_val;
                        D_ROT:   rot_reg[i]  <= sum_val;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            ov_reg <= {off_z, off_y, off_x};
        else if (cmd.prep_off)
        begin
            for (int i = 0; i < 3; i++)
                if (!local_reg)
                    ov_reg[i] <= sub_sat($signed(ov_reg[i]), $signed(pos_reg[i]));
        end
        else if (cmd.load_slot)
            ov_reg <= rdata_reg[191:96];

        if (cmd.load_slot)
            fv_reg <= rdata_reg[95:0];

        if (cmd.copy_sums)
        begin
            lat_reg <= la_reg;
            aat_reg <= aa_reg;
        end
        else if (cmd.zero_aaz)
            aat_reg[2] <= '0;

        if (wb_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (wb_idx_reg == 2'(i))
                begin
                    case (wb_dest_reg)
                        D_FV:    fv_reg[i]  <= q_val;
                        D_TQ:    tq_reg[i]  <= q_val;
                        D_LAT:   lat_reg[i] <= sum_val;
                        D_AAT:   aat_reg[i] <= sum_val;
                        default: ;
                    endcase
                end
            end
            case (wb_dest_reg)
                D_ACC_LD:  acc_reg <= 67'(prod_reg);
                D_ACC_ADD: acc_reg <= acc_reg + 67'(prod_reg);
                default: ;
            endcase
        end

        if (cmd.emit)
        begin
            pos_out_reg <= pos_reg;
            rot_out_reg <= rot_reg;
        end
    end

    // Force slot table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.slot_write && range_reg)
            mem[slot_reg] <= {ov_reg, fv_reg};
        if (cmd.slot_read)
            rdata_reg <= mem[slot_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.slot_write && range_reg)
            valid_reg[slot_reg] <= 1'b1;
    end

    assign stat.torque_disabled = td_reg;
    assign stat.impulse         = impulse_reg;
    assign stat.req             = req_reg;
    assign stat.slot_valid      = valid_reg[slot_addr];
    assign stat.lin_small       = acc_reg < LEN2_LIMIT;

    assign pos_x = pos_out_reg[0];
    assign pos_y = pos_out_reg[1];
    assign pos_z = pos_out_reg[2];
    assign rot_x = rot_out_reg[0];
    assign rot_y = rot_out_reg[1];
    assign rot_z = rot_out_reg[2];

endmodule

// File: design/rbfi_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the multiply/writeback operations of each item type.
// Depends on rbfi_pkg; drives rbfi_datapath through cmd_t.
module rbfi_ctrl
    import rbfi_pkg::*;
#(
    parameter int FORCE_SLOTS = FORCE_SLOTS_DEFAULT,
    localparam int SLOT_AW = (FORCE_SLOTS > 1) ? $clog2(FORCE_SLOTS) : 1,
    localparam int SLOT_CW = $clog2(FORCE_SLOTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    output logic               out_valid,
    input  logic               out_ready,
    input  stat_t              stat,
    output cmd_t               cmd,
    output logic [SLOT_AW-1:0] slot_addr
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_FV      = 5'd1;
    localparam logic [4:0] ST_FV_WAIT = 5'd2;
    localparam logic [4:0] ST_KWRITE  = 5'd3;
    localparam logic [4:0] ST_LIN     = 5'd4;
    localparam logic [4:0] ST_PREP    = 5'd5;
    localparam logic [4:0] ST_CROSS   = 5'd6;
    localparam logic [4:0] ST_ANG     = 5'd7;
    localparam logic [4:0] ST_S_INIT  = 5'd8;
    localparam logic [4:0] ST_S_READ  = 5'd9;
    localparam logic [4:0] ST_S_LOAD  = 5'd10;
    localparam logic [4:0] ST_S_SQ    = 5'd11;
    localparam logic [4:0] ST_S_SQW   = 5'd12;
    localparam logic [4:0] ST_S_TEST  = 5'd13;
    localparam logic [4:0] ST_S_LIN   = 5'd14;
    localparam logic [4:0] ST_S_CROSS = 5'd15;
    localparam logic [4:0] ST_S_ANG   = 5'd16;
    localparam logic [4:0] ST_S_FIN   = 5'd17;
    localparam logic [4:0] ST_S_VEL   = 5'd18;
    localparam logic [4:0] ST_S_POS   = 5'd19;
    localparam logic [4:0] ST_S_AVEL  = 5'd20;
    localparam logic [4:0] ST_S_ROT   = 5'd21;
    localparam logic [4:0] ST_S_DRAIN = 5'd22;
    localparam logic [4:0] ST_S_EMIT  = 5'd23;

    logic [4:0]         state_reg, state_next;
    logic [2:0]         k_reg, k_next;
    logic [SLOT_CW-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kk;
    logic               last3, last6;

    function automatic cmd_t mul_op(input logic [2:0] a_sel, input logic [1:0] a_idx,
                                    input logic [1:0] b_sel, input logic [1:0] b_idx,
                                    input logic [3:0] dest, input logic [1:0] dest_idx,
                                    input logic sub_acc);
        cmd_t c;
        c          = '0;
        c.mul_en   = 1'b1;
        c.a_sel    = a_sel;
        c.a_idx    = a_idx;
        c.b_sel    = b_sel;
        c.b_idx    = b_idx;
        c.dest     = dest;
        c.dest_idx = dest_idx;
        c.sub_acc  = sub_acc;
        return c;
    endfunction

    // Cross term k of fv x ov: the first product goes to the accumulator,
    // the second is subtracted from it on writeback.
    function automatic cmd_t cross_op(input logic [2:0] k, input logic [3:0] dest);
        logic [1:0] cm, ia, ib;
        cm = k[2:1];
        ia = next3(cm);
        ib = next3(ia);
        if (!k[0])
            return mul_op(A_FV, ia, B_OV, ib, D_ACC_LD, cm, 1'b0);
        else
            return mul_op(A_FV, ib, B_OV, ia, dest, cm, 1'b1);
    endfunction

    assign kk        = k_reg[1:0];
    assign last3     = (k_reg == 3'd2);
    assign last6     = (k_reg == 3'd5);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_addr = cnt_reg[SLOT_AW-1:0];

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    k_next      = 3'd0;
                    case (req_type)
                        REQ_IMMEDIATE: state_next = ST_FV;
                        REQ_KEYED:     state_next = ST_FV;
                        REQ_STEP:      state_next = ST_S_INIT;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FV:
            begin
                cmd    = mul_op(A_MAG, kk, B_DIR, kk, D_FV, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_FV_WAIT;
            end
            ST_FV_WAIT:
                state_next = (stat.req == REQ_KEYED) ? ST_KWRITE : ST_LIN;
            ST_KWRITE:
            begin
                cmd.slot_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_LIN:
            begin
                cmd    = mul_op(A_FV, kk, B_INVM, 2'd0, stat.impulse ? D_VEL : D_LA,
                                kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = stat.torque_disabled ? ST_IDLE : ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep_off = 1'b1;
                state_next   = ST_CROSS;
            end
            ST_CROSS:
            begin
                cmd    = cross_op(k_reg, D_TQ);
                k_next = last6 ? 3'd0 : k_reg + 3'd1;
                if (last6)
                    state_next = ST_ANG;
            end
            ST_ANG:
            begin
                cmd    = mul_op(A_TQ, kk, B_INVM, 2'd0, D_AA, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_IDLE;
            end
            ST_S_INIT:
            begin
                cmd.copy_sums = 1'b1;
                cnt_next      = '0;
                state_next    = ST_S_READ;
            end
            ST_S_READ:
            begin
                if (cnt_reg == SLOT_CW'(FORCE_SLOTS))
                    state_next = ST_S_FIN;
                else if (stat.slot_valid)
                begin
                    cmd.slot_read = 1'b1;
                    state_next    = ST_S_LOAD;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_S_LOAD:
            begin
                cmd.load_slot = 1'b1;
                k_next        = 3'd0;
                state_next    = ST_S_SQ;
            end
            ST_S_SQ:
            begin
                cmd    = mul_op(A_OV, kk, B_OV, kk, (k_reg == 3'd0) ? D_ACC_LD : D_ACC_ADD,
                                kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_S_SQW;
            end
            ST_S_SQW:
                state_next = ST_S_TEST;
            ST_S_TEST:
                state_next = stat.lin_small ? ST_S_LIN : ST_S_CROSS;
            ST_S_LIN:
            begin
                cmd    = mul_op(A_FV, kk, B_INVM, 2'd0, D_LAT, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_S_CROSS;
            end
            ST_S_CROSS:
            begin
                cmd    = cross_op(k_reg, D_TQ);
                k_next = last6 ? 3'd0 : k_reg + 3'd1;
                if (last6)
                    state_next = ST_S_ANG;
            end
            ST_S_ANG:
            begin
                cmd    = mul_op(A_TQ, kk, B_INVM, 2'd0, D_AAT, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_S_READ;
                end
            end
            ST_S_FIN:
            begin
                cmd.zero_aaz = 1'b1;
                k_next       = 3'd0;
                state_next   = ST_S_VEL;
            end
            ST_S_VEL:
            begin
                cmd    = mul_op(A_LAT, kk, B_DT, 2'd0, D_VEL, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_S_POS;
            end
            ST_S_POS:
            begin
                cmd    = mul_op(A_VEL, kk, B_DT, 2'd0, D_POS, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = stat.torque_disabled ? ST_S_DRAIN : ST_S_AVEL;
            end
            ST_S_AVEL:
            begin
                cmd    = mul_op(A_AAT, kk, B_DT, 2'd0, D_AVEL, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_S_ROT;
            end
            ST_S_ROT:
            begin
                cmd    = mul_op(A_AVEL, kk, B_DT, 2'd0, D_ROT, kk, 1'b0);
                k_next = last3 ? 3'd0 : k_reg + 3'd1;
                if (last3)
                    state_next = ST_S_DRAIN;
            end
            ST_S_DRAIN:
                state_next = ST_S_EMIT;
            ST_S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("result not presented after emit");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOT_CW'(FORCE_SLOTS))
        else $error("slot counter ran past the table");

    a_read_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slot_read |-> stat.slot_valid)
        else $error("read of a slot that was never written");

    a_rot_torque: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_AVEL || state_reg == ST_S_ROT) |-> !stat.torque_disabled)
        else $error("rotation integrated with torque disabled");
`endif

endmodule

// File: design/rigid_body_force_integrator.sv
`timescale 1ns / 1ps
// Immediate: force, linear and (with torque) angular terms; keyed: force then slot write.
// One shared multiplier. Time step: sums valid slots, then integrates velocity and pose.
// Throughput is one item at a time; the pose output register frees the input side.
// Reset clears body state, slot valid bits and configuration (inverse_mass = 1.0).
// The slot table itself is not cleared; slots are only read after being written.
module rigid_body_force_integrator
    import rbfi_pkg::*;
#(
    parameter int FORCE_SLOTS = FORCE_SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] magnitude,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] off_x,
    input  logic signed [31:0] off_y,
    input  logic signed [31:0] off_z,
    input  logic               local_offset,
    input  logic               is_impulse,
    input  logic [3:0]         slot,
    input  logic [15:0]        time_delta,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SLOT_AW = (FORCE_SLOTS > 1) ? $clog2(FORCE_SLOTS) : 1;

    cmd_t               cmd;
    stat_t              stat;
    logic [SLOT_AW-1:0] slot_addr;

    rbfi_ctrl #(
        .FORCE_SLOTS (FORCE_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .slot_addr (slot_addr)
    );

    rbfi_datapath #(
        .FORCE_SLOTS (FORCE_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slot_addr    (slot_addr),
        .stat         (stat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .magnitude    (magnitude),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .off_x        (off_x),
        .off_y        (off_y),
        .off_z        (off_z),
        .local_offset (local_offset),
        .is_impulse   (is_impulse),
        .slot         (slot),
        .time_delta   (time_delta),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .rot_x        (rot_x),
        .rot_y        (rot_y),
        .rot_z        (rot_z)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rigid_body_force_integrator: random and directed forces and steps.
// Depends on rbfi_pkg and the integrator RTL; predicts each pose in fixed point locally.
module tb_top;
    import rbfi_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         req;
        logic signed [31:0] mag;
        logic signed [31:0] dx, dy, dz;
        logic signed [31:0] ox, oy, oz;
        logic               loc;
        logic               imp;
        logic [3:0]         sl;
        logic [15:0]        dt;
    } force_req_t;

    typedef struct packed {
        logic signed [31:0] px, py, pz, rx, ry, rz;
    } pose_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] req_type;
    logic signed [31:0] magnitude, dir_x, dir_y, dir_z, off_x, off_y, off_z;
    logic local_offset, is_impulse;
    logic [3:0] slot;
    logic [15:0] time_delta;
    logic signed [31:0] pos_x, pos_y, pos_z, rot_x, rot_y, rot_z;
    logic cfg_write, cfg_index;
    logic [31:0] cfg_data;

    rigid_body_force_integrator u_top (.*);

    force_req_t pending_reqs[$];
    pose_t      expected_poses[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    // Predictor state.
    logic [31:0]        m_invm;
    logic               m_notorque;
    logic signed [31:0] m_vel[3], m_la[3], m_avel[3], m_aa[3], m_pos[3], m_rot[3];
    logic signed [31:0] m_sf[NSLOT][3], m_so[NSLOT][3];
    logic               m_sv[NSLOT];

    function automatic logic signed [31:0] sat64(input logic signed [66:0] v);
        if (v > 67'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -67'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [33:0] b);
        logic signed [66:0] p;
        p = 67'(a) * 67'(b);
        return sat64(p >>> 16);
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat64(67'(a) + 67'(b));
    endfunction

    function automatic logic signed [31:0] xcomp(input logic signed [31:0] a1,
                                                 input logic signed [31:0] b2,
                                                 input logic signed [31:0] a2,
                                                 input logic signed [31:0] b1);
        logic signed [66:0] p;
        p = 67'(a1) * 67'(b2) - 67'(a2) * 67'(b1);
        return sat64(p >>> 16);
    endfunction

    task automatic scale_into(inout logic signed [31:0] acc[3],
                              input logic signed [31:0] v[3]);
        for (int i = 0; i < 3; i++)
            acc[i] = sadd(acc[i], qmul(v[i], {2'b00, m_invm}));
    endtask

    task automatic torque_of(input logic signed [31:0] f[3], input logic signed [31:0] o[3],
                             output logic signed [31:0] t[3]);
        t[0] = xcomp(f[1], o[2], f[2], o[1]);
        t[1] = xcomp(f[2], o[0], f[0], o[2]);
        t[2] = xcomp(f[0], o[1], f[1], o[0]);
    endtask

    task automatic predict_integrator(input force_req_t r);
        logic signed [31:0] fv[3], ov[3], tq[3], la[3], aa[3];
        logic signed [66:0] len2;
        logic signed [33:0] dt;
        pose_t p;
        fv[0] = qmul(r.mag, r.dx);
        fv[1] = qmul(r.mag, r.dy);
        fv[2] = qmul(r.mag, r.dz);
        ov[0] = r.ox;
        ov[1] = r.oy;
        ov[2] = r.oz;
        case (r.req)
            REQ_IMMEDIATE:
            begin
                if (r.imp)
                    scale_into(m_vel, fv);
                else
                    scale_into(m_la, fv);
                if (!m_notorque)
                begin
                    if (!r.loc)
                        for (int i = 0; i < 3; i++)
                            ov[i] = sat64(67'(ov[i]) - 67'(m_pos[i]));
                    torque_of(fv, ov, tq);
                    scale_into(m_aa, tq);
                end
            end
            REQ_KEYED:
            begin
                m_sf[r.sl] = fv;
                m_so[r.sl] = ov;
                m_sv[r.sl] = 1'b1;
            end
            REQ_STEP:
            begin
                dt = {18'd0, r.dt};
                la = m_la;
                aa = m_aa;
                for (int s = 0; s < NSLOT; s++)
                begin
                    if (m_sv[s])
                    begin
                        len2 = 0;
                        for (int i = 0; i < 3; i++)
                            len2 += 67'(m_so[s][i]) * 67'(m_so[s][i]);
                        if (len2 < 67'sd42949673)
                            scale_into(la, m_sf[s]);
                        torque_of(m_sf[s], m_so[s], tq);
                        scale_into(aa, tq);
                    end
                end
                aa[2] = 0;
                for (int i = 0; i < 3; i++)
                begin
                    m_vel[i] = sadd(m_vel[i], qmul(la[i], dt));
                    m_pos[i] = sadd(m_pos[i], qmul(m_vel[i], dt));
                end
                if (!m_notorque)
                    for (int i = 0; i < 3; i++)
                    begin
                        m_avel[i] = sadd(m_avel[i], qmul(aa[i], dt));
                        m_rot[i] = sadd(m_rot[i], qmul(m_avel[i], dt));
                    end
                p = '{m_pos[0], m_pos[1], m_pos[2], m_rot[0], m_rot[1], m_rot[2]};
                expected_poses.push_back(p);
            end
            default:;
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                force_req_t r;
                r = pending_reqs.pop_front();
                predict_integrator(r);
                in_valid     <= 1'b1;
                req_type     <= r.req;
                magnitude    <= r.mag;
                dir_x        <= r.dx;
                dir_y        <= r.dy;
                dir_z        <= r.dz;
                off_x        <= r.ox;
                off_y        <= r.oy;
                off_z        <= r.oz;
                local_offset <= r.loc;
                is_impulse   <= r.imp;
                slot         <= r.sl;
                time_delta   <= r.dt;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_poses.size() == 0)
            begin
                $error("pose with none expected");
                errors++;
            end
            else
            begin
                pose_t e;
                e = expected_poses.pop_front();
                if (pos_x !== e.px) begin $error("pos_x exp %0d got %0d", e.px, pos_x); errors++; end
                if (pos_y !== e.py) begin $error("pos_y exp %0d got %0d", e.py, pos_y); errors++; end
                if (pos_z !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, pos_z); errors++; end
                if (rot_x !== e.rx) begin $error("rot_x exp %0d got %0d", e.rx, rot_x); errors++; end
                if (rot_y !== e.ry) begin $error("rot_y exp %0d got %0d", e.ry, rot_y); errors++; end
                if (rot_z !== e.rz) begin $error("rot_z exp %0d got %0d", e.rz, rot_z); errors++; end
            end
        end
    end

    function automatic logic signed [31:0] rand_q(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(131072)) - 32'sd65536;
            2: return $signed($urandom_range(8192)) - 32'sd4096;
            default: return $signed($urandom_range(16777216)) - 32'sd8388608;
        endcase
    endfunction

    function automatic force_req_t rand_req();
        force_req_t r;
        int m, k;
        m = $urandom_range(9);
        k = (m < 2) ? 0 : (m < 7) ? 1 : (m < 9) ? 3 : 2;
        r.req = ($urandom_range(99) < 3) ? REQ_NONE :
                ($urandom_range(99) < 35) ? REQ_STEP :
                ($urandom_range(1) ? REQ_KEYED : REQ_IMMEDIATE);
        r.mag = rand_q(k);
        r.dx  = rand_q(k);
        r.dy  = rand_q(k);
        r.dz  = rand_q(k);
        r.ox  = rand_q($urandom_range(3) == 0 ? 2 : k);
        r.oy  = rand_q($urandom_range(3) == 0 ? 2 : k);
        r.oz  = rand_q($urandom_range(3) == 0 ? 2 : k);
        r.loc = $urandom_range(1);
        r.imp = $urandom_range(1);
        r.sl  = $urandom_range(15);
        r.dt  = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(2000));
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_INVERSE_MASS)
            m_invm = val;
        else
            m_notorque = val[0];
    endtask

    task automatic push_req(input logic [1:0] rq, input logic signed [31:0] mg,
                            input logic signed [31:0] d, input logic signed [31:0] o,
                            input logic lo, input logic im, input logic [3:0] s,
                            input logic [15:0] t);
        force_req_t r;
        r = '{rq, mg, d, -d, d, o, o, -o, lo, im, s, t};
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_INVERSE_MASS;
        cfg_data = '0;
        {req_type, magnitude, dir_x, dir_y, dir_z, off_x, off_y, off_z} = '0;
        {local_offset, is_impulse, slot, time_delta} = '0;
        m_invm = INVM_RESET;
        m_notorque = 1'b0;
        for (int i = 0; i < 3; i++)
            {m_vel[i], m_la[i], m_avel[i], m_aa[i], m_pos[i], m_rot[i]} = '0;
        for (int s = 0; s < NSLOT; s++)
            m_sv[s] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every request type, small and large slot offsets.
        push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        push_req(REQ_IMMEDIATE, 32'sh10000, 32'sh10000, 32'sh20000, 0, 0, 0, 100);
        push_req(REQ_IMMEDIATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1, 1, 0, 0);
        push_req(REQ_IMMEDIATE, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 0, 1, 0, 0);
        push_req(REQ_KEYED, 32'sh10000, 32'sh100, 32'sh100, 1, 1, 4'd0, 0);
        push_req(REQ_KEYED, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 4'd15, 0);
        push_req(REQ_KEYED, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 0, 0, 4'd7, 0);
        push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 16'd1000);
        push_req(REQ_NONE, -1, -1, -1, 1, 1, 4'd15, 16'hFFFF);
        push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 16'd0);
        wait_drained();
        write_reg(REG_TORQUE_DISABLED, 32'd1);
        write_reg(REG_INVERSE_MASS, 32'hFFFFFFFF);
        push_req(REQ_IMMEDIATE, 32'sh10000, 32'sh30000, 32'sh10000, 0, 0, 0, 0);
        push_req(REQ_IMMEDIATE, 32'sh10000, 32'sh30000, 32'sh10000, 0, 1, 0, 0);
        push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 16'd500);
        wait_drained();
        write_reg(REG_TORQUE_DISABLED, 32'd0);
        write_reg(REG_INVERSE_MASS, 32'd0);
        push_req(REQ_IMMEDIATE, 32'sh10000, 32'sh30000, 32'sh10000, 0, 0, 0, 0);
        push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, 16'd500);
        wait_drained();

        // Random phases, each with its own settings; consecutive pairs share an idle pattern.
        for (int ph = 0; ph < 6; ph++)
        begin
            logic [31:0] im;
            im = (ph == 5) ? 32'h7FFF_FFFF : (ph == 4) ? 32'h0 : $urandom_range(32'h40000);
            write_reg(REG_INVERSE_MASS, im);
            write_reg(REG_TORQUE_DISABLED, (ph == 2) ? 32'd1 : 32'd0);
            send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 79 : 0;
            recv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 7 : 0;
            for (int n = 0; n < 205; n++)
                pending_reqs.push_back(rand_req());
            wait_drained();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
